// File: rtl/sfd_pkg.sv
// Shared types and constants for the S.BUS frame decoder.
// No dependencies; imported by every module of the block.
package sfd_pkg;

  localparam int CHANNELS    = 16;
  localparam int DATA_BYTES  = 22;
  localparam int RAW_W       = 11;
  localparam int FRAME_W     = DATA_BYTES * 8;
  localparam int CH_W        = 4;
  localparam int POS_W       = 5;
  localparam int GAIN_W      = 17;
  localparam int OFFSET_W    = 32;
  localparam int PROD_W      = RAW_W + GAIN_W;
  localparam int SCALED_W    = 16;

  localparam logic [7:0] HEADER_BYTE = 8'h0F;
  localparam logic [7:0] FOOTER_BYTE = 8'h00;

  localparam logic [POS_W-1:0] POS_HUNT   = 5'd0;
  localparam logic [POS_W-1:0] POS_LAST_DATA = 5'd22;
  localparam logic [POS_W-1:0] POS_FLAGS  = 5'd23;
  localparam logic [POS_W-1:0] POS_FOOTER = 5'd24;

  localparam logic [CH_W-1:0] LAST_CH = 4'd15;

  // Register indexes of the configuration port
  localparam logic REG_GAIN   = 1'b0;
  localparam logic REG_OFFSET = 1'b1;

  localparam logic [GAIN_W-1:0]   GAIN_RESET   = 17'd41009;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 32'd57359305;

  // Frame handed from the sync front end to the queue
  typedef struct packed {
    logic               valid;
    logic [FRAME_W-1:0] data;
  } frame_push_t;

  // Queue status seen by the producer and the consumer
  typedef struct packed {
    logic not_empty;
    logic full;
  } queue_status_t;

endpackage

// File: rtl/sfd_front.sv
// Byte-wise frame sync: hunts for the header, collects the data bytes,
// checks the footer and pushes good frames. Depends on sfd_pkg.
module sfd_front import sfd_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    rx_byte,
  input  queue_status_t q_status,
  output frame_push_t   push
);

  logic [POS_W-1:0]   pos;
  logic [POS_W-1:0]   pos_next;
  logic [FRAME_W-1:0] store;
  logic               take;
  logic               at_data;

  // Hold off the footer byte while no queue slot is free
  assign in_stall = (pos == POS_FOOTER) && q_status.full;
  assign take     = in_valid && !in_stall;
  assign at_data  = (pos != POS_HUNT) && (pos <= POS_LAST_DATA);

  // Advance the frame position
  always_comb begin
    pos_next = pos;
    priority if (pos == POS_HUNT) begin
      if (rx_byte == HEADER_BYTE) pos_next = 5'd1;
    end else if (at_data || pos == POS_FLAGS) begin
      pos_next = pos + 5'd1;
    end else begin
      pos_next = POS_HUNT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= POS_HUNT;
    end else if (take) begin
      pos <= pos_next;
    end
  end

  // Shift data bytes in from the top so byte 0 ends at the bottom
  always_ff @(posedge clk) begin
    if (take && at_data) begin
      store <= {rx_byte, store[FRAME_W-1:8]};
    end
  end

  // Push the frame on a good footer
  assign push.valid = take && (pos == POS_FOOTER) && (rx_byte == FOOTER_BYTE);
  assign push.data  = store;

`ifndef ASSERT_OFF
  a_pos_range: assert property (@(posedge clk) disable iff (rst) pos <= POS_FOOTER)
    else $error("frame position out of range");
  a_push_footer: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> $past(pos) == POS_FLAGS || $past(!take) || $past(pos) == POS_FOOTER)
    else $error("push away from footer");
`endif

endmodule

// File: rtl/sfd_queue.sv
// Two-entry frame queue between the sync front end and the channel back end.
// Depends on sfd_pkg.
module sfd_queue import sfd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  frame_push_t        push,
  input  logic               pop,
  output queue_status_t      status,
  output logic [FRAME_W-1:0] head
);

  logic [FRAME_W-1:0] slot [2];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         count;

  assign status.not_empty = (count != 2'd0);
  assign status.full      = (count == 2'd2);
  assign head             = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slot[wr_ptr] <= push.data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push.valid) wr_ptr <= ~wr_ptr;
      if (pop)        rd_ptr <= ~rd_ptr;
      unique case ({push.valid, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push.valid && status.full && !pop))
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> status.not_empty)
    else $error("queue underflow");
`endif

endmodule

// File: rtl/sfd_back.sv
// Channel back end: unpacks one channel a cycle from the queued frame while
// the output is not stalled, scales it in Q16, saturates and holds it in the
// output register. Depends on sfd_pkg.
module sfd_back import sfd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [OFFSET_W-1:0] cfg_data,
  input  queue_status_t       q_status,
  input  logic [FRAME_W-1:0]  head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CH_W-1:0]     channel_index,
  output logic [RAW_W-1:0]    raw_value,
  output logic [SCALED_W-1:0] scaled_value,
  output logic                last_channel
);

  logic [GAIN_W-1:0]   gain;
  logic [OFFSET_W-1:0] offset;
  logic [CH_W-1:0]     ch;
  logic                adv;
  logic                issue;

  logic                s1_valid;
  logic [CH_W-1:0]     s1_idx;
  logic [RAW_W-1:0]    s1_raw;
  logic                s2_valid;
  logic [CH_W-1:0]     s2_idx;
  logic [RAW_W-1:0]    s2_raw;
  logic [PROD_W-1:0]   s2_prod;
  logic [OFFSET_W:0]   sum;
  logic [SCALED_W:0]   shifted;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gain   <= GAIN_RESET;
      offset <= OFFSET_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GAIN:   gain   <= cfg_data[GAIN_W-1:0];
        REG_OFFSET: offset <= cfg_data;
        default:    gain   <= gain;
      endcase
    end
  end

  // Move the whole pipeline whenever the output slot can take a transfer
  assign adv   = !out_valid || !out_stall;
  assign issue = adv && q_status.not_empty;
  assign pop   = issue && (ch == LAST_CH);

  always_ff @(posedge clk) begin
    if (rst) begin
      ch        <= '0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      if (issue) ch <= ch + 4'd1;
      s1_valid  <= issue;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  // Offset add and Q16 shift; saturation follows in the output register
  assign sum     = {{(OFFSET_W + 1 - PROD_W){1'b0}}, s2_prod} + {1'b0, offset};
  assign shifted = sum[OFFSET_W:16];

  // Stage payloads: unpack, multiply, then scale into the output register
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_idx        <= ch;
      s1_raw        <= head[RAW_W*ch +: RAW_W];
      s2_idx        <= s1_idx;
      s2_raw        <= s1_raw;
      s2_prod       <= PROD_W'(s1_raw) * PROD_W'(gain);
      channel_index <= s2_idx;
      raw_value     <= s2_raw;
      last_channel  <= (s2_idx == LAST_CH);
      scaled_value  <= shifted[SCALED_W] ? {SCALED_W{1'b1}} : shifted[SCALED_W-1:0];
    end
  end

`ifndef ASSERT_OFF
  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_channel |-> channel_index == LAST_CH)
    else $error("last flag on wrong channel");
  a_pop_last: assert property (@(posedge clk) disable iff (rst)
    pop |=> s1_valid && s1_idx == LAST_CH)
    else $error("frame popped before its last channel");
`endif

endmodule

// File: rtl/sbus_frame_decoder_core.sv
// A good frame waits in a queue slot; its 16 channels pass the unpack, multiply
// and output registers, one channel per cycle while the output is not stalled.
// Throughput: one byte per cycle; the footer byte is held off only while
// both frame queue slots are taken. Output stall freezes the back end pipeline.
// Reset (synchronous, rst high) returns to header hunt, empties the queue
// and restores gain and offset defaults. No clearing pass is needed.
module sbus_frame_decoder_core import sfd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [OFFSET_W-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          rx_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CH_W-1:0]     channel_index,
  output logic [RAW_W-1:0]    raw_value,
  output logic [SCALED_W-1:0] scaled_value,
  output logic                last_channel
);

  frame_push_t        push;
  queue_status_t      q_status;
  logic [FRAME_W-1:0] head;
  logic               pop;

  sfd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .q_status (q_status),
    .push     (push)
  );

  sfd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .pop    (pop),
    .status (q_status),
    .head   (head)
  );

  sfd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .q_status      (q_status),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .channel_index (channel_index),
    .raw_value     (raw_value),
    .scaled_value  (scaled_value),
    .last_channel  (last_channel)
  );

endmodule
